@@ design/mrta_pkg.sv @@
// ----------------------------------------------------------------------------
// mrta_pkg: shared types and constants of the duration accumulator
// Digit widths, action and unit codes and the radix helper.
// ----------------------------------------------------------------------------
package mrta_pkg;

    localparam int unsigned YEAR_W  = 16;
    localparam int unsigned DIGIT_W = 10;
    localparam int unsigned AMT_W   = 32;
    localparam int unsigned NUM_RAD = 6;

    typedef enum logic [1:0] {
        ACT_ADD = 2'd0,
        ACT_SUB = 2'd1,
        ACT_SET = 2'd2,
        ACT_CMP = 2'd3
    } action_t;

    localparam logic [2:0] UNIT_SEC   = 3'd4;
    localparam logic [2:0] UNIT_MILLI = 3'd5;
    localparam logic [2:0] UNIT_MICRO = 3'd6;

    localparam logic [1:0] ORD_EQ = 2'd0;
    localparam logic [1:0] ORD_GT = 2'd1;
    localparam logic [1:0] ORD_LT = 2'd2;

    // Radix of a register value: zero means 1024.
    function automatic logic [DIGIT_W:0] eff_radix(input logic [DIGIT_W-1:0] r);
        eff_radix = (r == '0) ? {1'b1, {DIGIT_W{1'b0}}} : {1'b0, r};
    endfunction

endpackage

@@ design/mrta_div.sv @@
// ----------------------------------------------------------------------------
// mrta_div: bit-serial restoring divider
// Divides a 32-bit dividend by an 11-bit radix, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mrta_div
    import mrta_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic [AMT_W-1:0]    dividend,
    input  logic [DIGIT_W:0]    divisor,
    output logic                done,
    output logic [AMT_W-1:0]    quotient,
    output logic [DIGIT_W:0]    remainder
);

    localparam int unsigned CNT_W = $clog2(AMT_W + 1);

    logic [AMT_W-1:0]   q_reg, q_next;
    logic [DIGIT_W+1:0] r_reg, r_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               run_reg, run_next;
    logic               done_reg, done_next;
    logic [DIGIT_W+1:0] trial;
    logic [DIGIT_W+1:0] shifted;

    always_comb begin
        q_next    = q_reg;
        r_next    = r_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        shifted   = {r_reg[DIGIT_W:0], q_reg[AMT_W-1]};
        trial     = shifted - {1'b0, divisor};
        if (start) begin
            q_next   = dividend;
            r_next   = '0;
            cnt_next = CNT_W'(AMT_W);
            run_next = 1'b1;
        end else if (run_reg) begin
            // restore when the trial goes negative
            if (!trial[DIGIT_W+1]) begin
                r_next = trial;
                q_next = {q_reg[AMT_W-2:0], 1'b1};
            end else begin
                r_next = shifted;
                q_next = {q_reg[AMT_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        q_reg <= q_next;
        r_reg <= r_next;
        if (!aresetn) begin
            cnt_reg  <= '0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    assign done      = done_reg;
    assign quotient  = q_reg;
    assign remainder = r_reg[DIGIT_W:0];

endmodule

@@ design/mixed_radix_time_accumulator.sv @@
// ----------------------------------------------------------------------------
// mixed_radix_time_accumulator: seven-digit mixed-radix duration accumulator
// Adds, subtracts, sets or compares durations against a stored value.
// ----------------------------------------------------------------------------
// Channel | Direction | Fields (low bit up)
// s_axis  | in        | tdata: amount[31:0], unit[34:32]; tuser: action[1:0]
// m_axis  | out       | tdata: years, days, hours, minutes, seconds, millis,
//         |           |        micros (10 each above years); tuser: order[1:0]
// cfg     | in        | cfg_we, cfg_addr[2:0], cfg_wdata[9:0]
//
// Flow: each item takes one radix division per digit on the shared
// bit-serial divider (up to six divisions), then a digit pass that adds or
// subtracts from micros up to years (a single compare step for compare).
// Reset clears all digits and restores the radix registers.
// s_axis_tready is low while an item is in work or its result waits; the
// result register holds until m_axis_tready.
// ----------------------------------------------------------------------------
module mixed_radix_time_accumulator
    import mrta_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // amount[31:0], unit[34:32], zero pad
    input  logic [1:0]  s_axis_tuser,   // action[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [79:0] m_axis_tdata,   // years, days, hours, minutes, seconds,
                                        // millis, micros, zero pad
    output logic [1:0]  m_axis_tuser,   // order[1:0]
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [9:0]  cfg_wdata
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_DIV   = 5'b00010,
        ST_WAIT  = 5'b00100,
        ST_DIGIT = 5'b01000,
        ST_OUT   = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic [DIGIT_W-1:0] radix_reg [NUM_RAD];
    logic [YEAR_W-1:0]  year_reg, year_next;
    logic [DIGIT_W-1:0] dig_reg [NUM_RAD];
    logic [DIGIT_W-1:0] dig_next [NUM_RAD];
    logic [DIGIT_W-1:0] sd_reg [NUM_RAD];     // split digits, day..micro
    logic [DIGIT_W-1:0] sd_next [NUM_RAD];
    logic [AMT_W-1:0]   rest_reg, rest_next;
    logic [2:0]         k_reg, k_next;        // digit position, 0..6 (0 is years)
    logic [1:0]         act_reg, act_next;
    logic               cy_reg, cy_next;      // carry or borrow
    logic [1:0]         ord_reg, ord_next;
    logic               ord_set_reg, ord_set_next;
    logic               out_v_reg, out_v_next;

    logic               div_start;
    logic               div_done;
    logic               div_busy;
    logic [AMT_W-1:0]   quo;
    logic [DIGIT_W:0]   rem;
    logic [DIGIT_W:0]   cur_rad;
    logic [2:0]         in_unit;
    logic [AMT_W-1:0]   in_amt;

    assign cur_rad = eff_radix(radix_reg[k_reg - 3'd1]);

    mrta_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (rest_reg),
        .divisor   (cur_rad),
        .done      (div_done),
        .quotient  (quo),
        .remainder (rem)
    );

    assign div_busy = (state_reg == ST_WAIT);

    // Radix registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radix_reg[0] <= 10'd365;
            radix_reg[1] <= 10'd24;
            radix_reg[2] <= 10'd60;
            radix_reg[3] <= 10'd60;
            radix_reg[4] <= 10'd1000;
            radix_reg[5] <= 10'd1000;
        end else if (cfg_we && cfg_addr < 3'(NUM_RAD)) begin
            radix_reg[cfg_addr] <= cfg_wdata;
        end
    end

    logic [DIGIT_W+1:0] sum;
    logic [DIGIT_W+1:0] take;
    logic [DIGIT_W-1:0] cur;
    logic [DIGIT_W-1:0] sd;
    logic [YEAR_W-1:0]  yd;

    always_comb begin
        state_next   = state_reg;
        year_next    = year_reg;
        dig_next     = dig_reg;
        sd_next      = sd_reg;
        rest_next    = rest_reg;
        k_next       = k_reg;
        act_next     = act_reg;
        cy_next      = cy_reg;
        ord_next     = ord_reg;
        ord_set_next = ord_set_reg;
        out_v_next   = out_v_reg;
        div_start    = 1'b0;
        in_unit      = (s_axis_tdata[34:32] == 3'd7) ? UNIT_MICRO : s_axis_tdata[34:32];
        in_amt       = s_axis_tdata[31:0];
        cur          = dig_reg[k_reg - 3'd1];
        sd           = sd_reg[k_reg - 3'd1];
        sum          = '0;
        take         = '0;
        yd           = rest_reg[YEAR_W-1:0];
        case (state_reg)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    act_next = s_axis_tuser;
                    for (int i = 0; i < NUM_RAD; i++) sd_next[i] = '0;
                    if (action_t'(s_axis_tuser) == ACT_CMP) begin
                        k_next    = UNIT_MILLI;
                        rest_next = in_amt;
                    end else begin
                        k_next    = in_unit;
                        rest_next = (in_unit <= UNIT_SEC) ? {16'd0, in_amt[15:0]} : in_amt;
                    end
                    if (action_t'(s_axis_tuser) == ACT_SET) begin
                        year_next = '0;
                        for (int i = 0; i < NUM_RAD; i++) dig_next[i] = '0;
                    end
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                // split one digit per division, from the item's unit upward
                if (k_reg == 3'd0) begin
                    k_next       = 3'd6;
                    cy_next      = 1'b0;
                    ord_next     = ORD_EQ;
                    ord_set_next = 1'b0;
                    state_next   = ST_DIGIT;
                end else begin
                    div_start  = 1'b1;
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT: begin
                if (div_done) begin
                    sd_next[k_reg - 3'd1] = rem[DIGIT_W-1:0];
                    rest_next  = quo;
                    k_next     = k_reg - 3'd1;
                    state_next = ST_DIV;
                end
            end
            ST_DIGIT: begin
                if (action_t'(act_reg) == ACT_CMP) begin
                    // compare from years down: first difference wins
                    if (!ord_set_reg) begin
                        if (year_reg != yd) begin
                            ord_next     = (year_reg > yd) ? ORD_GT : ORD_LT;
                            ord_set_next = 1'b1;
                        end else begin
                            for (int i = NUM_RAD - 1; i >= 0; i--) begin
                                if (dig_reg[i] != sd_reg[i]) begin
                                    ord_next = (dig_reg[i] > sd_reg[i]) ? ORD_GT : ORD_LT;
                                end
                            end
                            ord_set_next = 1'b1;
                        end
                    end
                    out_v_next = 1'b1;
                    state_next = ST_OUT;
                end else if (k_reg != 3'd0) begin
                    if (action_t'(act_reg) == ACT_SUB) begin
                        take = {2'b0, sd} + {11'd0, cy_reg};
                        if (take > {2'b0, cur}) begin
                            sum     = {2'b0, cur} + {1'b0, cur_rad} - take;
                            cy_next = 1'b1;
                        end else begin
                            sum     = {2'b0, cur} - take;
                            cy_next = 1'b0;
                        end
                    end else begin
                        sum = {2'b0, cur} + {2'b0, sd} + {11'd0, cy_reg};
                        if (sum >= {1'b0, cur_rad}) begin
                            sum     = sum - {1'b0, cur_rad};
                            cy_next = 1'b1;
                        end else begin
                            cy_next = 1'b0;
                        end
                    end
                    dig_next[k_reg - 3'd1] = sum[DIGIT_W-1:0];
                    k_next = k_reg - 3'd1;
                end else begin
                    if (action_t'(act_reg) == ACT_SUB)
                        year_next = year_reg - yd - {15'd0, cy_reg};
                    else
                        year_next = year_reg + yd + {15'd0, cy_reg};
                    ord_next   = ORD_EQ;
                    out_v_next = 1'b1;
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (m_axis_tready) begin
                    out_v_next = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        sd_reg   <= sd_next;
        rest_reg <= rest_next;
        k_reg    <= k_next;
        act_reg  <= act_next;
        cy_reg   <= cy_next;
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            year_reg    <= '0;
            for (int i = 0; i < NUM_RAD; i++) dig_reg[i] <= '0;
            ord_reg     <= ORD_EQ;
            ord_set_reg <= 1'b0;
            out_v_reg   <= 1'b0;
        end else begin
            state_reg   <= state_next;
            year_reg    <= year_next;
            dig_reg     <= dig_next;
            ord_reg     <= ord_next;
            ord_set_reg <= ord_set_next;
            out_v_reg   <= out_v_next;
        end
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_v_reg;
    assign m_axis_tdata  = {4'd0, dig_reg[5], dig_reg[4], dig_reg[3], dig_reg[2],
                            dig_reg[1], dig_reg[0], year_reg};
    assign m_axis_tuser  = ord_reg;

    // Assertions.
    a_valid_state : assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> state_reg == ST_OUT) else $error("result outside OUT");
    a_no_accept_busy : assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> !s_axis_tready) else $error("input taken while result waits");
    a_order_zero : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && action_t'(act_reg) != ACT_CMP) |-> m_axis_tuser == ORD_EQ)
        else $error("order set on non-compare");
    a_div_wait : assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> div_busy) else $error("divider done outside wait");

endmodule

@@ tb/mixed_radix_time_accumulator_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mixed_radix_time_accumulator_test: self-checking bench of the accumulator
// Drives add, subtract, set and compare transactions with random gaps and
// back-pressure, rewrites the radix registers between phases and checks each
// result against an in-bench model of the digit arithmetic.
// ----------------------------------------------------------------------------

class duration_scoreboard;
    logic [9:0]  radix [6];
    logic [15:0] year_q;
    logic [9:0]  digit_q [6];
    logic [79:0] want_data [$];
    logic [1:0]  want_order [$];
    int          errors;

    function new();
        errors = 0;
        restore();
    endfunction

    function void restore();
        radix[0] = 10'd365; radix[1] = 10'd24; radix[2] = 10'd60;
        radix[3] = 10'd60;  radix[4] = 10'd1000; radix[5] = 10'd1000;
        year_q = '0;
        foreach (digit_q[i]) digit_q[i] = '0;
    endfunction

    function int unsigned rad(int k);
        return (radix[k-1] == 0) ? 1024 : radix[k-1];
    endfunction

    // Split an amount into digits from unit u up to years.
    function void split(logic [31:0] amount, int u, ref int unsigned d [7]);
        int unsigned rest;
        rest = amount;
        foreach (d[i]) d[i] = 0;
        for (int k = u; k >= 1; k--) begin
            d[k] = rest % rad(k);
            rest = rest / rad(k);
        end
        d[0] = rest & 16'hFFFF;
    endfunction

    function void note_input(mrta_pkg::action_t act, logic [31:0] amount, logic [2:0] unit);
        int unsigned d [7];
        int unsigned c, s, t;
        int u;
        logic [1:0] ord;
        ord = mrta_pkg::ORD_EQ;
        u = (unit > 6) ? 6 : unit;
        if (act == mrta_pkg::ACT_CMP) begin
            split(amount, 5, d);
            if (year_q != d[0]) begin
                ord = (year_q > d[0]) ? mrta_pkg::ORD_GT : mrta_pkg::ORD_LT;
            end else begin
                for (int k = 1; k <= 6; k++) begin
                    if (ord == mrta_pkg::ORD_EQ && digit_q[k-1] != d[k]) begin
                        ord = (digit_q[k-1] > d[k]) ? mrta_pkg::ORD_GT : mrta_pkg::ORD_LT;
                    end
                end
            end
        end else begin
            if (u < 5) amount = amount & 32'hFFFF;
            split(amount, u, d);
            if (act == mrta_pkg::ACT_SET) begin
                year_q = '0;
                foreach (digit_q[i]) digit_q[i] = '0;
            end
            c = 0;
            for (int k = 6; k >= 1; k--) begin
                if (act == mrta_pkg::ACT_SUB) begin
                    t = d[k] + c;
                    if (t > digit_q[k-1]) begin
                        s = digit_q[k-1] + rad(k) - t;
                        c = 1;
                    end else begin
                        s = digit_q[k-1] - t;
                        c = 0;
                    end
                end else begin
                    s = digit_q[k-1] + d[k] + c;
                    c = 0;
                    if (s >= rad(k)) begin
                        s = s - rad(k);
                        c = 1;
                    end
                end
                digit_q[k-1] = s[9:0];
            end
            if (act == mrta_pkg::ACT_SUB) year_q = year_q - d[0][15:0] - c[15:0];
            else year_q = year_q + d[0][15:0] + c[15:0];
        end
        want_data.push_back({4'b0, digit_q[5], digit_q[4], digit_q[3], digit_q[2],
                             digit_q[1], digit_q[0], year_q});
        want_order.push_back(ord);
    endfunction

    function void check_result(logic [79:0] data, logic [1:0] ord);
        logic [79:0] w;
        logic [1:0]  wo;
        string names [7] = '{"years", "days", "hours", "minutes", "seconds",
                             "millis", "micros"};
        if (want_data.size() == 0) begin
            $error("result with no expectation waiting");
            errors++;
            return;
        end
        w = want_data.pop_front();
        wo = want_order.pop_front();
        if (w[15:0] !== data[15:0]) begin
            $error("%s: expected %0d, actual %0d", names[0], w[15:0], data[15:0]);
            errors++;
        end
        for (int i = 1; i < 7; i++) begin
            if (w[16+(i-1)*10 +: 10] !== data[16+(i-1)*10 +: 10]) begin
                $error("%s: expected %0d, actual %0d", names[i],
                       w[16+(i-1)*10 +: 10], data[16+(i-1)*10 +: 10]);
                errors++;
            end
        end
        if (wo !== ord) begin
            $error("order: expected %0d, actual %0d", wo, ord);
            errors++;
        end
    endfunction
endclass

module mixed_radix_time_accumulator_test;
    import mrta_pkg::*;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [79:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_addr = '0;
    logic [9:0]  cfg_wdata = '0;

    duration_scoreboard ledger = new();
    bit quiet_tail = 0;   // no idling near the end

    mixed_radix_time_accumulator dut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Watchdog: far beyond the slowest run (~950 items plus stalls).
    initial begin
        #20_000_000;
        $display("Verification failed");
        $finish;
    end

    // Result side: random back-pressure bursts, check every accepted transaction.
    initial begin
        int hold;
        forever begin
            @(posedge aclk);
            if (aresetn && m_axis_tvalid && m_axis_tready)
                ledger.check_result(m_axis_tdata, m_axis_tuser);
            if (hold > 0) begin
                hold--;
                m_axis_tready <= 1'b0;
            end else if (!quiet_tail && $urandom_range(0, 3) == 0) begin
                hold = $urandom_range(0, 2);
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Send one transaction; sometimes idle a random burst first, then wait for the handshake.
    // Valid stays high after the handshake; the next idle or the caller drops it.
    task automatic send_item(action_t act, logic [31:0] amount, logic [2:0] unit);
        if (!quiet_tail && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'b0, unit, amount};
        s_axis_tuser  <= act;
        do @(posedge aclk); while (!s_axis_tready);
        ledger.note_input(act, amount, unit);
    endtask

    // Drop valid, drain all results, let the block settle, then write a register.
    task automatic write_radix(logic [2:0] idx, logic [9:0] val);
        s_axis_tvalid <= 1'b0;
        while (ledger.want_data.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        ledger.radix[idx] = val;
    endtask

    task automatic random_items(int n);
        logic [31:0] amt;
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 3))
                0: amt = $urandom();
                1: amt = $urandom_range(0, 2000);
                2: amt = 32'hFFFF_FFFF - $urandom_range(0, 100);
                default: amt = $urandom() >> $urandom_range(0, 31);
            endcase
            send_item(action_t'($urandom_range(0, 3)), amt, 3'($urandom_range(0, 7)));
        end
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: every action, every unit, field extremes, year wrap.
        send_item(ACT_CMP, 32'd0, 3'd0);
        send_item(ACT_SUB, 32'd1, UNIT_MICRO);          // underflow wraps years
        send_item(ACT_ADD, 32'd1, UNIT_MICRO);
        send_item(ACT_SET, 32'hFFFF_FFFF, 3'd0);
        send_item(ACT_ADD, 32'd1, 3'd0);                // year overflow
        for (int u = 0; u < 8; u++) send_item(ACT_ADD, 32'hFFFF_FFFF, 3'(u));
        send_item(ACT_CMP, 32'hFFFF_FFFF, 3'd7);
        send_item(ACT_SET, 32'd1500, UNIT_MILLI);
        send_item(ACT_CMP, 32'd1500, UNIT_SEC);         // equal
        send_item(ACT_CMP, 32'd1499, UNIT_SEC);         // stored greater
        send_item(ACT_CMP, 32'd1501, UNIT_SEC);         // stored less
        send_item(ACT_SUB, 32'hFFFF_FFFF, UNIT_MILLI);
        send_item(ACT_SUB, 32'h0001_FFFF, UNIT_SEC);

        random_items(250);

        // Small radices, zero (taken as 1024) and max; stale digits follow.
        write_radix(3'd0, 10'd1);
        write_radix(3'd1, 10'd0);
        write_radix(3'd2, 10'd1023);
        write_radix(3'd3, 10'd2);
        write_radix(3'd4, 10'd3);
        write_radix(3'd5, 10'd0);
        random_items(200);

        for (int i = 0; i < 6; i++) write_radix(3'(i), 10'($urandom_range(0, 1023)));
        random_items(200);

        for (int i = 0; i < 6; i++) write_radix(3'(i), 10'd1023);
        random_items(150);

        for (int i = 0; i < 6; i++) write_radix(3'(i), 10'($urandom_range(1, 12)));
        quiet_tail = 1;
        random_items(130);
        s_axis_tvalid <= 1'b0;

        while (ledger.want_data.size() != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
        if (ledger.errors == 0 && ledger.want_data.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
